// ----- sv/mrfg_pkg.sv -----
// Shared types, sizes and result codes for the multichannel ring FIFO gather block.
package mrfg_pkg;

  localparam int CHANNELS = 32;
  localparam int DEPTH    = 16;

  localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int PTR_W  = $clog2(DEPTH);
  localparam int ADDR_W = (CHANNELS * DEPTH > 2) ? $clog2(CHANNELS * DEPTH) : 1;

  localparam logic [1:0] KIND_PUSH = 2'd0;
  localparam logic [1:0] KIND_HDR  = 2'd1;
  localparam logic [1:0] KIND_DATA = 2'd2;

  typedef struct packed {
    logic        mode;
    logic [5:0]  channel;
    logic [63:0] word_in;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic        accepted;
    logic [31:0] chan_mask;
    logic [5:0]  out_channel;
    logic [63:0] word_out;
    logic [3:0]  fill_count;
    logic        last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic            capture;
    logic            push;
    logic            hdr;
    logic            issue;
    logic [CH_W-1:0] idx;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mask_nonzero;
  } stat_t;

endpackage

// ----- sv/multichannel_ring_fifo_gather.sv -----
// Top level of the multichannel ring FIFO gather block.
//
// Each of CHANNELS channels owns a circular FIFO of DEPTH-1 usable 64-bit slots.
// An input beat is taken when start is high and busy is low. Mode 0 pushes
// word_in into one channel; mode 1 pops across all channels.
// A push answers with one result beat (accept flag and new fill count) from
// the result register after the push state; busy is high for one cycle, so
// the next beat is taken only once the push state is over.
// A pop first emits a header beat with the mask of non-empty channels, from
// the result register after the header state. With a nonzero mask it then
// emits one data beat per channel, in channel order, one per cycle; each goes
// through the registered entry memory read and the result register, which leaves
// a gap after the header. busy stays high through the header and pop states.
// An empty pop emits only the header, marked last.
// Results appear on out_item for exactly one cycle with out_valid high; the
// receiver cannot stall, so no back pressure exists.
// Reset clears all read and write pointers, which empties every channel;
// the entry memory is not cleared and needs no clearing pass.
module multichannel_ring_fifo_gather
  import mrfg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  in_item_t  in_item,
  output logic      out_valid,
  output out_item_t out_item
);

  cmd_t  cmd;
  stat_t stat;

  mrfg_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .pop_req (in_item.mode),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  mrfg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// ----- sv/mrfg_ctrl.sv -----
// Controller state machine that sequences push and gathered pop operations.
module mrfg_ctrl
  import mrfg_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  logic  pop_req,
  input  stat_t stat,
  output cmd_t  cmd,
  output logic  busy
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_PUSH = 2'd1;
  localparam logic [1:0] ST_HDR  = 2'd2;
  localparam logic [1:0] ST_POP  = 2'd3;

  logic [1:0]      state_r, state_nxt;
  logic [CH_W-1:0] idx_r, idx_nxt;

  always_comb begin
    state_nxt   = state_r;
    idx_nxt     = idx_r;
    cmd         = '0;
    cmd.idx     = idx_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_nxt   = pop_req ? ST_HDR : ST_PUSH;
        end
      end
      ST_PUSH: begin
        cmd.push  = 1'b1;
        state_nxt = ST_IDLE;
      end
      ST_HDR: begin
        cmd.hdr = 1'b1;
        idx_nxt = '0;
        state_nxt = stat.mask_nonzero ? ST_POP : ST_IDLE;
      end
      ST_POP: begin
        cmd.issue = 1'b1;
        if (idx_r == CH_W'(CHANNELS - 1)) begin
          state_nxt = ST_IDLE;
        end else begin
          idx_nxt = idx_r + 1'b1;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      idx_r   <= '0;
    end else begin
      state_r <= state_nxt;
      idx_r   <= idx_nxt;
    end
  end

endmodule

// ----- sv/mrfg_dp.sv -----
// Datapath: per-channel pointers, the entry memory, the pop read pipeline and the result register.
module mrfg_dp
  import mrfg_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cmd_t      cmd,
  output stat_t     stat,
  output logic      out_valid,
  output out_item_t out_item
);

  logic [63:0]       mem [CHANNELS*DEPTH];
  logic [PTR_W-1:0]  wp_r [CHANNELS];
  logic [PTR_W-1:0]  rp_r [CHANNELS];

  logic [5:0]        chan_r;
  logic [63:0]       word_r;
  logic [CHANNELS-1:0] mask_r;
  logic [63:0]       rdata_r;

  logic              p1_valid_r;
  logic [CH_W-1:0]   p1_ch_r;
  logic              p1_sel_r;
  logic              p1_last_r;

  logic              out_valid_r;
  out_item_t         out_r, out_nxt;

  logic [CH_W-1:0]     rd_ch;
  logic [PTR_W-1:0]    wp_cur, rp_cur, wp_inc, rp_inc, w_new;
  logic                in_range, push_ok;
  logic [PTR_W:0]      cnt;
  logic [ADDR_W-1:0]   base, wr_addr, rd_addr;
  logic [CHANNELS-1:0] nonempty;

  // One pointer pair is looked at per cycle: the pushed channel or the pop index.
  assign rd_ch    = cmd.issue ? cmd.idx : CH_W'(chan_r);
  assign wp_cur   = wp_r[rd_ch];
  assign rp_cur   = rp_r[rd_ch];
  assign wp_inc   = (wp_cur == PTR_W'(DEPTH - 1)) ? '0 : wp_cur + 1'b1;
  assign rp_inc   = (rp_cur == PTR_W'(DEPTH - 1)) ? '0 : rp_cur + 1'b1;
  assign in_range = ({1'b0, chan_r} < 7'(CHANNELS));
  assign push_ok  = in_range && (wp_inc != rp_cur);
  assign w_new    = push_ok ? wp_inc : wp_cur;

  // Occupancy wraps: add the depth back when the write pointer is behind.
  assign cnt = {1'b0, w_new} - {1'b0, rp_cur} +
               ((w_new < rp_cur) ? (PTR_W+1)'(DEPTH) : '0);

  assign base    = ADDR_W'(rd_ch) * ADDR_W'(DEPTH);
  assign wr_addr = base + ADDR_W'(wp_cur);
  assign rd_addr = base + ADDR_W'(rp_cur);

  always_comb begin
    for (int c = 0; c < CHANNELS; c++) begin
      nonempty[c] = (wp_r[c] != rp_r[c]);
    end
  end

  assign stat.mask_nonzero = |nonempty;

  always_comb begin
    out_nxt = '0;
    if (cmd.push) begin
      out_nxt.kind       = KIND_PUSH;
      out_nxt.accepted   = push_ok;
      out_nxt.fill_count = in_range ? 4'(cnt) : 4'd0;
      out_nxt.last       = 1'b1;
    end else if (cmd.hdr) begin
      out_nxt.kind      = KIND_HDR;
      out_nxt.accepted  = |nonempty;
      out_nxt.chan_mask = 32'(nonempty);
      out_nxt.last      = ~|nonempty;
    end else begin
      out_nxt.kind        = KIND_DATA;
      out_nxt.accepted    = 1'b1;
      out_nxt.out_channel = 6'(p1_ch_r);
      out_nxt.word_out    = p1_sel_r ? rdata_r : 64'd0;
      out_nxt.last        = p1_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push && push_ok) begin
      mem[wr_addr] <= word_r;
    end
    if (cmd.issue) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        wp_r[c] <= '0;
        rp_r[c] <= '0;
      end
    end else begin
      if (cmd.push && push_ok) begin
        wp_r[rd_ch] <= wp_inc;
      end
      if (cmd.issue && mask_r[cmd.idx]) begin
        rp_r[rd_ch] <= rp_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      p1_valid_r  <= cmd.issue;
      out_valid_r <= cmd.push || cmd.hdr || p1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      chan_r <= in_item.channel;
      word_r <= in_item.word_in;
    end
    if (cmd.hdr) begin
      mask_r <= nonempty;
    end
    p1_ch_r   <= cmd.idx;
    p1_sel_r  <= mask_r[cmd.idx];
    p1_last_r <= (cmd.idx == CH_W'(CHANNELS - 1));
    out_r     <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

endmodule

// ----- sv/mrfg_checker.sv -----
// Port-level checker for the multichannel ring FIFO gather block, with its bind.
module mrfg_checker
  import mrfg_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input in_item_t  in_item,
  input logic      out_valid,
  input out_item_t out_item
);

  // A taken beat keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("busy did not rise after an accepted beat");

  // A taken push is answered by a push result beat with out_valid high.
  a_push_answer: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy && !in_item.mode |-> ##2 (out_valid && out_item.kind == KIND_PUSH))
    else $error("push answer missing");

  // A push answer is always the final beat of its item.
  a_push_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_PUSH |-> out_item.last)
    else $error("push answer not marked last");

  // An empty pop header carries no mask and ends the item.
  a_empty_hdr: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_HDR && !out_item.accepted |->
      out_item.last && out_item.chan_mask == 32'd0)
    else $error("empty pop header malformed");

  // Data beats never carry header or push fields.
  a_data_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_item.kind == KIND_DATA |->
      out_item.accepted && out_item.chan_mask == 32'd0 && out_item.fill_count == 4'd0)
    else $error("data beat carries stray fields");

endmodule

bind multichannel_ring_fifo_gather mrfg_checker u_mrfg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .in_item   (in_item),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ----- bench/tb.sv -----
// Self-checking testbench for the multichannel ring FIFO gather block.
`timescale 1ns / 1ps

module tb
  import mrfg_pkg::*;
;

  localparam int unsigned RANDOM_ITEMS = 480;
  localparam int unsigned CYCLE_LIMIT  = 300000;
  localparam int unsigned PRINT_LIMIT  = 60;

  // Tracks every channel's ring and the beats still owed by the block.
  class fifo_gather_board;
    logic [63:0] slots [CHANNELS][DEPTH];
    int unsigned wr_idx [CHANNELS];
    int unsigned rd_idx [CHANNELS];
    out_item_t   owed_beats [$];
    int unsigned mismatches;

    function new();
      for (int i = 0; i < CHANNELS; i++) begin
        wr_idx[i] = 0;
        rd_idx[i] = 0;
      end
      mismatches = 0;
    endfunction

    function int unsigned fill_of(int unsigned ch);
      return (DEPTH + wr_idx[ch] - rd_idx[ch]) % DEPTH;
    endfunction

    function int unsigned pending();
      return owed_beats.size();
    endfunction

    // Works out the beats that one accepted command will produce.
    function void take_command(in_item_t cmd);
      out_item_t   beat;
      logic [63:0] mask;
      int unsigned ch;
      int unsigned nxt;
      beat = '0;
      if (!cmd.mode) begin
        beat.kind = KIND_PUSH;
        beat.last = 1'b1;
        ch = cmd.channel;
        if (ch < CHANNELS) begin
          nxt = (wr_idx[ch] + 1) % DEPTH;
          if (nxt != rd_idx[ch]) begin
            slots[ch][wr_idx[ch]] = cmd.word_in;
            wr_idx[ch] = nxt;
            beat.accepted = 1'b1;
          end
          beat.fill_count = 4'(fill_of(ch));
        end
        owed_beats.push_back(beat);
        return;
      end
      mask = '0;
      for (int i = 0; i < CHANNELS && i < 64; i++)
        if (fill_of(i) > 0) mask[i] = 1'b1;
      beat.kind = KIND_HDR;
      if (mask == '0) begin
        beat.last = 1'b1;
        owed_beats.push_back(beat);
        return;
      end
      beat.accepted  = 1'b1;
      beat.chan_mask = mask[31:0];
      owed_beats.push_back(beat);
      for (int i = 0; i < CHANNELS && i < 64; i++) begin
        beat = '0;
        beat.kind        = KIND_DATA;
        beat.accepted    = 1'b1;
        beat.out_channel = 6'(i);
        beat.last        = (i == CHANNELS - 1);
        if (mask[i]) begin
          beat.word_out = slots[i][rd_idx[i]];
          rd_idx[i] = (rd_idx[i] + 1) % DEPTH;
        end
        owed_beats.push_back(beat);
      end
    endfunction

    task flag_mismatch(string msg);
      if (mismatches < PRINT_LIMIT) $display("[%0t] mismatch: %s", $time, msg);
      mismatches++;
    endtask

    task compare_field(string name, logic [63:0] got, logic [63:0] want);
      if (got !== want)
        flag_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    task check_beat(out_item_t got);
      out_item_t want;
      if (owed_beats.size() == 0) begin
        flag_mismatch($sformatf("result beat with nothing outstanding: 0x%0h", got));
        return;
      end
      want = owed_beats.pop_front();
      compare_field("kind", 64'(got.kind), 64'(want.kind));
      compare_field("accepted", 64'(got.accepted), 64'(want.accepted));
      compare_field("chan_mask", 64'(got.chan_mask), 64'(want.chan_mask));
      compare_field("out_channel", 64'(got.out_channel), 64'(want.out_channel));
      compare_field("word_out", got.word_out, want.word_out);
      compare_field("fill_count", 64'(got.fill_count), 64'(want.fill_count));
      compare_field("last", 64'(got.last), 64'(want.last));
    endtask
  endclass

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      start = 1'b0;
  logic      busy;
  in_item_t  in_item = '0;
  logic      out_valid;
  out_item_t out_item;

  fifo_gather_board board;
  int unsigned      cycle_count = 0;

  multichannel_ring_fifo_gather DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("** multichannel_ring_fifo_gather: FAILED **");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid) board.check_beat(out_item);
  end

  function automatic in_item_t make_cmd(logic mode, int unsigned ch, logic [63:0] word);
    in_item_t cmd;
    cmd.mode    = mode;
    cmd.channel = 6'(ch);
    cmd.word_in = word;
    return cmd;
  endfunction

  // Pops are rare, common or close to half the commands depending on the burst;
  // pushes lean on a few neighboring channels so that rings fill up and wrap.
  function automatic in_item_t random_cmd(int unsigned pop_pct, int unsigned hot);
    in_item_t    cmd;
    int unsigned roll;
    roll = $urandom_range(99);
    cmd.word_in = {$urandom(), $urandom()};
    cmd.mode    = (roll < pop_pct);
    if (roll < pop_pct)
      cmd.channel = 6'($urandom_range(63));
    else if (roll < pop_pct + 8)
      cmd.channel = 6'($urandom_range(63, CHANNELS));
    else if ($urandom_range(1))
      cmd.channel = 6'(hot + $urandom_range(2));
    else
      cmd.channel = 6'($urandom_range(CHANNELS - 1));
    return cmd;
  endfunction

  // Called at a falling edge; returns at the falling edge after the beat is taken.
  task send_cmd(in_item_t cmd);
    in_item <= cmd;
    start   <= 1'b1;
    do @(posedge clk); while (busy);
    board.take_command(cmd);
    @(negedge clk);
  endtask

  task idle_sender(int unsigned cycles);
    if (cycles > 0) begin
      start <= 1'b0;
      repeat (cycles) @(negedge clk);
    end
  endtask

  initial begin
    int unsigned sent;
    int unsigned burst;
    int unsigned pop_pct;
    int unsigned hot;
    board = new();
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part: empty pop, field extremes, out-of-range channels, a full ring.
    send_cmd(make_cmd(1'b1, 0, '0));
    send_cmd(make_cmd(1'b0, 0, '1));
    send_cmd(make_cmd(1'b0, CHANNELS - 1, '0));
    send_cmd(make_cmd(1'b0, CHANNELS, 64'hA5A5_5A5A_F0F0_0F0F));
    send_cmd(make_cmd(1'b0, 63, 64'h5555_AAAA_5555_AAAA));
    send_cmd(make_cmd(1'b1, 63, '1));
    for (int i = 0; i < DEPTH - 1; i++)
      send_cmd(make_cmd(1'b0, 5, {$urandom(), $urandom()}));
    send_cmd(make_cmd(1'b0, 5, '1));
    send_cmd(make_cmd(1'b1, 0, '0));
    send_cmd(make_cmd(1'b0, 5, 64'h8000_0000_0000_0001));
    send_cmd(make_cmd(1'b1, 0, '0));

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      case ($urandom_range(2))
        0: pop_pct = 3;
        1: pop_pct = 15;
        default: pop_pct = 45;
      endcase
      hot   = $urandom_range(CHANNELS - 3);
      burst = $urandom_range(24, 1);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_cmd(random_cmd(pop_pct, hot));
        sent++;
      end
      case ($urandom_range(3))
        0: idle_sender(0);
        3: idle_sender($urandom_range(20, 5));
        default: idle_sender($urandom_range(4, 1));
      endcase
    end
    start <= 1'b0;

    while (board.pending() != 0) @(posedge clk);
    repeat (CHANNELS + 8) @(posedge clk);
    if (board.mismatches == 0)
      $display("** multichannel_ring_fifo_gather: PASSED **");
    else
      $display("** multichannel_ring_fifo_gather: FAILED **");
    $finish;
  end

endmodule
